// File: rtl/core/ipss_pkg.sv
// Shared constants, payload types and register codes of the instruction pair signature scanner.
package ipss_pkg;

  // Width of the running word index; it wraps at 2**INDEX_BITS.
  localparam int INDEX_BITS = 30;
  // Words per page. Page starts are found from the low index bits, so this is a power of two.
  localparam int PAGE_WORDS = 1024;
  localparam int PAGE_BITS  = $clog2(PAGE_WORDS);

  localparam int WORD_BITS      = 32;
  localparam int OUT_BITS       = 30;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [OUT_BITS-1:0]   out_index_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_HALF_PATTERN    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_HALF_PATTERN   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAIR_MASK           = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGISTER_FIELD_MASK = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROLOGUE_MASK       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROLOGUE_PATTERN    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_MAGIC        = 3'd6;

  // Register values after reset.
  localparam word_t RST_LOW_HALF_PATTERN    = 32'hE30D_0600;
  localparam word_t RST_HIGH_HALF_PATTERN   = 32'hE340_0083;
  localparam word_t RST_PAIR_MASK           = 32'hFFFF_0FFF;
  localparam word_t RST_REGISTER_FIELD_MASK = 32'h0000_F000;
  localparam word_t RST_PROLOGUE_MASK       = 32'hFFFF_0000;
  localparam word_t RST_PROLOGUE_PATTERN    = 32'hE92D_0000;
  localparam word_t RST_HEADER_MAGIC        = 32'h464C_457F;

  typedef struct packed {
    word_t low_half_pattern;
    word_t high_half_pattern;
    word_t pair_mask;
    word_t register_field_mask;
    word_t prologue_mask;
    word_t prologue_pattern;
    word_t header_magic;
  } ipss_cfg_t;

  typedef struct packed {
    word_t data_word;
    logic  first_word;
  } ipss_in_t;

  typedef struct packed {
    out_index_t candidate_index;
    logic       prologue_found;
    out_index_t pair_end_index;
    out_index_t image_base_index;
    logic       image_found;
  } ipss_out_t;

endpackage

// File: rtl/core/ipss_cfg_regs.sv
// Configuration register file of the instruction pair signature scanner.
module ipss_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ipss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  ipss_pkg::word_t                     cfg_data,
  output ipss_pkg::ipss_cfg_t                 cfg
);

  ipss_pkg::ipss_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_half_pattern    <= ipss_pkg::RST_LOW_HALF_PATTERN;
      regs.high_half_pattern   <= ipss_pkg::RST_HIGH_HALF_PATTERN;
      regs.pair_mask           <= ipss_pkg::RST_PAIR_MASK;
      regs.register_field_mask <= ipss_pkg::RST_REGISTER_FIELD_MASK;
      regs.prologue_mask       <= ipss_pkg::RST_PROLOGUE_MASK;
      regs.prologue_pattern    <= ipss_pkg::RST_PROLOGUE_PATTERN;
      regs.header_magic        <= ipss_pkg::RST_HEADER_MAGIC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipss_pkg::REG_LOW_HALF_PATTERN:    regs.low_half_pattern    <= cfg_data;
        ipss_pkg::REG_HIGH_HALF_PATTERN:   regs.high_half_pattern   <= cfg_data;
        ipss_pkg::REG_PAIR_MASK:           regs.pair_mask           <= cfg_data;
        ipss_pkg::REG_REGISTER_FIELD_MASK: regs.register_field_mask <= cfg_data;
        ipss_pkg::REG_PROLOGUE_MASK:       regs.prologue_mask       <= cfg_data;
        ipss_pkg::REG_PROLOGUE_PATTERN:    regs.prologue_pattern    <= cfg_data;
        ipss_pkg::REG_HEADER_MAGIC:        regs.header_magic        <= cfg_data;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: rtl/core/instruction_pair_signature_scanner_core.sv
// Top level of the instruction pair signature scanner: scan state, result buffer, assertions.
//
//   channel   direction  handshake                     payload
//   item      in         item_valid / item_stall       ipss_in_t  (data_word, first_word)
//   result    out        result_valid / result_stall   ipss_out_t (indices and found flags)
//   cfg       in         cfg_we                        cfg_index, cfg_data
//
// Each request is evaluated in the cycle it is accepted: one word per clock while item_stall
// is low, set by the single compare-and-update path from the item port into the scan state
// registers. A completed pair is written to a two-entry result buffer (output register plus
// skid). item_stall is high only while the skid entry is occupied, so a waiting result does
// not hold up the next request. Reset is synchronous; there is no clearing pass.
module instruction_pair_signature_scanner_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  ipss_pkg::ipss_in_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ipss_pkg::ipss_out_t                 result,
  input  logic                                cfg_we,
  input  logic [ipss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  ipss_pkg::word_t                     cfg_data
);

  localparam int IndexBits = ipss_pkg::INDEX_BITS;
  localparam int PageBits  = ipss_pkg::PAGE_BITS;
  localparam int OutBits   = ipss_pkg::OUT_BITS;

  // Pair phase codes. The unused code behaves as waiting.
  localparam logic [1:0] PHASE_WAIT = 2'd0;
  localparam logic [1:0] PHASE_LOW  = 2'd1;
  localparam logic [1:0] PHASE_HIGH = 2'd2;

  ipss_pkg::ipss_cfg_t cfg;

  ipss_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Scan state. The snapshot registers hold the header tracker as it stood when the
  // most recent prologue word was captured, so a result reports the image base that
  // belongs to its prologue rather than a later header.
  logic [1:0]       phase;
  ipss_pkg::word_t  held_field;
  ipss_pkg::index_t word_index;
  ipss_pkg::index_t prologue_index;
  logic             prologue_valid;
  ipss_pkg::index_t header_index;
  logic             header_valid;
  ipss_pkg::index_t snap_header_index;
  logic             snap_header_valid;

  logic [1:0]       phase_next;
  ipss_pkg::word_t  held_field_next;
  ipss_pkg::index_t prologue_index_next;
  logic             prologue_valid_next;
  ipss_pkg::index_t header_index_next;
  logic             header_valid_next;
  ipss_pkg::index_t snap_header_index_next;
  logic             snap_header_valid_next;

  // Result buffer.
  logic                result_full;
  ipss_pkg::ipss_out_t result_data;
  logic                skid_valid;
  ipss_pkg::ipss_out_t skid_data;

  logic                item_accept;
  logic                result_take;
  logic                done;
  ipss_pkg::ipss_out_t res;

  // Per-word evaluation signals.
  logic [1:0]       cur_phase;
  ipss_pkg::word_t  cur_held;
  ipss_pkg::index_t idx;
  ipss_pkg::index_t cur_prologue_index;
  logic             cur_prologue_valid;
  ipss_pkg::index_t cur_header_index;
  logic             cur_header_valid;
  ipss_pkg::index_t cur_snap_index;
  logic             cur_snap_valid;
  ipss_pkg::word_t  masked;
  ipss_pkg::word_t  field;
  logic             is_low;
  logic             is_high;
  logic             header_hit;
  logic             prologue_hit;
  logic             img;
  ipss_pkg::index_t base;

  assign item_stall   = skid_valid;
  assign item_accept  = item_valid && !item_stall;
  assign result_valid = result_full;
  assign result       = result_data;
  assign result_take  = result_full && !result_stall;

  always_comb begin
    // A first word restarts the dump before the word itself is looked at.
    if (item.first_word) begin
      cur_phase          = PHASE_WAIT;
      cur_held           = '0;
      idx                = '0;
      cur_prologue_index = '0;
      cur_prologue_valid = 1'b0;
      cur_header_index   = '0;
      cur_header_valid   = 1'b0;
      cur_snap_index     = '0;
      cur_snap_valid     = 1'b0;
    end else begin
      cur_phase          = phase;
      cur_held           = held_field;
      idx                = word_index;
      cur_prologue_index = prologue_index;
      cur_prologue_valid = prologue_valid;
      cur_header_index   = header_index;
      cur_header_valid   = header_valid;
      cur_snap_index     = snap_header_index;
      cur_snap_valid     = snap_header_valid;
    end

    // Index zero counts as a page start too.
    header_hit   = (idx[PageBits-1:0] == '0) && (item.data_word == cfg.header_magic);
    prologue_hit = (item.data_word & cfg.prologue_mask) == cfg.prologue_pattern;

    header_index_next = header_hit ? idx : cur_header_index;
    header_valid_next = header_hit || cur_header_valid;

    // The snapshot sees a header found on this same word.
    prologue_index_next    = prologue_hit ? idx : cur_prologue_index;
    prologue_valid_next    = prologue_hit || cur_prologue_valid;
    snap_header_index_next = prologue_hit ? header_index_next : cur_snap_index;
    snap_header_valid_next = prologue_hit ? header_valid_next : cur_snap_valid;

    masked  = item.data_word & cfg.pair_mask;
    field   = item.data_word & cfg.register_field_mask;
    is_low  = masked == cfg.low_half_pattern;
    is_high = masked == cfg.high_half_pattern;

    // Once one half is held, only the opposite half with the same register field
    // completes the pair; anything else leaves the held half in place.
    done            = 1'b0;
    phase_next      = cur_phase;
    held_field_next = cur_held;
    unique case (cur_phase)
      PHASE_LOW: begin
        done = is_high && (field == cur_held);
      end
      PHASE_HIGH: begin
        done = is_low && (field == cur_held);
      end
      default: begin
        // A word that matches both halves is taken as the low half.
        if (is_low) begin
          phase_next      = PHASE_LOW;
          held_field_next = field;
        end else if (is_high) begin
          phase_next      = PHASE_HIGH;
          held_field_next = field;
        end else begin
          phase_next = PHASE_WAIT;
        end
      end
    endcase

    img  = prologue_valid_next ? snap_header_valid_next : header_valid_next;
    base = prologue_valid_next ? snap_header_index_next : header_index_next;

    res.candidate_index  = OutBits'(prologue_valid_next ? prologue_index_next : idx);
    res.prologue_found   = prologue_valid_next;
    res.pair_end_index   = OutBits'(idx);
    res.image_base_index = img ? OutBits'(base) : '0;
    res.image_found      = img;

    // A completed pair restarts the scan with the next word; the header tracker stays.
    if (done) begin
      phase_next             = PHASE_WAIT;
      held_field_next        = '0;
      prologue_index_next    = '0;
      prologue_valid_next    = 1'b0;
      snap_header_index_next = '0;
      snap_header_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PHASE_WAIT;
      held_field        <= '0;
      word_index        <= '0;
      prologue_index    <= '0;
      prologue_valid    <= 1'b0;
      header_index      <= '0;
      header_valid      <= 1'b0;
      snap_header_index <= '0;
      snap_header_valid <= 1'b0;
    end else if (item_accept) begin
      phase             <= phase_next;
      held_field        <= held_field_next;
      word_index        <= idx + IndexBits'(1);
      prologue_index    <= prologue_index_next;
      prologue_valid    <= prologue_valid_next;
      header_index      <= header_index_next;
      header_valid      <= header_valid_next;
      snap_header_index <= snap_header_index_next;
      snap_header_valid <= snap_header_valid_next;
    end
  end

  // Result buffer: the skid entry only fills when a new result arrives while the
  // output register is held, and it drains into the output register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_full <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        result_data <= skid_data;
        skid_valid  <= 1'b0;
      end
    end else if (item_accept && done) begin
      if (result_full && !result_take) begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end else begin
        result_data <= res;
        result_full <= 1'b1;
      end
    end else if (result_take) begin
      result_full <= 1'b0;
    end
  end

  // The skid entry is never occupied without a result waiting in front of it.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_full)
    else $error("skid entry holds a result while the output register is empty");

  // The first word of a dump leaves the index pointing at the second word.
  a_first_word_index: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.first_word) |=> (word_index == IndexBits'(1)))
    else $error("word index did not restart on the first word of a dump");

  // A completed pair restarts the scan.
  a_pair_restarts_scan: assert property (@(posedge clk) disable iff (rst)
    (item_accept && done) |=> (phase == PHASE_WAIT && !prologue_valid))
    else $error("scan state not cleared after a completed pair");

  // A result is produced only in a phase that holds one half.
  a_done_needs_half: assert property (@(posedge clk) disable iff (rst)
    done |-> (cur_phase == PHASE_LOW || cur_phase == PHASE_HIGH))
    else $error("pair completed without a held half");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the instruction pair signature scanner core.
module testbench;
  import ipss_pkg::*;

  typedef enum logic [1:0] {PH_WAIT, PH_HAVE_LOW, PH_HAVE_HIGH} pair_phase_e;
  typedef enum logic [1:0] {IDLE_SEND_HEAVY, IDLE_RECV_HEAVY, IDLE_NONE} idle_mode_e;

  // One entry of the stimulus plan: either a register write or a dump word request.
  typedef struct {
    bit                        is_cfg;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    word_t                     value;
    ipss_in_t                  req;
    idle_mode_e                mode;
  } scan_op_t;

  localparam int RANDOM_WORDS  = 1560;
  localparam int SETTING_SPAN  = 260;
  localparam int MODE_SPAN     = 520;
  // One long dump crosses a page boundary so that a header past index zero is seen.
  localparam int LONG_START    = 300;
  localparam int LONG_WORDS    = 1100;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STUCK_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 60;

  localparam ipss_cfg_t RESET_SETTING = '{RST_LOW_HALF_PATTERN, RST_HIGH_HALF_PATTERN,
      RST_PAIR_MASK, RST_REGISTER_FIELD_MASK, RST_PROLOGUE_MASK, RST_PROLOGUE_PATTERN,
      RST_HEADER_MAGIC};
  // Every word matches both halves, is a prologue, and all fields compare equal.
  localparam ipss_cfg_t ZERO_SETTING  = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
  // Exact-word compares: the all-ones word is low half, prologue and header at once.
  localparam ipss_cfg_t ONES_SETTING  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  ipss_in_t                  item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  ipss_out_t                 result;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  word_t                     cfg_data = '0;

  instruction_pair_signature_scanner_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Stimulus plan, the scan results still owed by the block, and the error count.
  scan_op_t   scan_ops_q[$];
  ipss_out_t  pair_results_q[$];
  int         errors = 0;
  idle_mode_e active_mode = IDLE_SEND_HEAVY;
  int         quiet_cycles = 0;

  // Predictor state: the register file and the scan state as the block holds them.
  ipss_cfg_t   model_cfg = RESET_SETTING;
  pair_phase_e pair_phase = PH_WAIT;
  word_t       held_field = '0;
  index_t      word_idx = '0;
  index_t      prologue_idx = '0;
  logic        prologue_seen = 1'b0;
  index_t      header_idx = '0;
  logic        header_seen = 1'b0;
  // Header tracker as it stood when the last prologue word was captured.
  index_t      snap_header_idx = '0;
  logic        snap_header_seen = 1'b0;

  // Register file as the plan builder sees it; it runs ahead of the predictor.
  ipss_cfg_t   plan_cfg = RESET_SETTING;
  index_t      plan_index = '0;
  idle_mode_e  plan_mode = IDLE_SEND_HEAVY;

  function automatic ipss_cfg_t with_reg(ipss_cfg_t c, logic [CFG_INDEX_BITS-1:0] i,
                                         word_t v);
    case (i)
      REG_LOW_HALF_PATTERN:    c.low_half_pattern    = v;
      REG_HIGH_HALF_PATTERN:   c.high_half_pattern   = v;
      REG_PAIR_MASK:           c.pair_mask           = v;
      REG_REGISTER_FIELD_MASK: c.register_field_mask = v;
      REG_PROLOGUE_MASK:       c.prologue_mask       = v;
      REG_PROLOGUE_PATTERN:    c.prologue_pattern    = v;
      REG_HEADER_MAGIC:        c.header_magic        = v;
      default: ;
    endcase
    return c;
  endfunction

  function automatic void restart_scan();
    pair_phase       = PH_WAIT;
    held_field       = '0;
    prologue_idx     = '0;
    prologue_seen    = 1'b0;
    snap_header_idx  = '0;
    snap_header_seen = 1'b0;
  endfunction

  // Advances the predicted scan state by one word; returns 1 when the word completes a pair.
  function automatic bit scan_word(input ipss_in_t req, output ipss_out_t res);
    word_t  w;
    word_t  field;
    index_t idx;
    logic   is_low;
    logic   is_high;
    logic   done;
    logic   img;
    index_t base;
    w    = req.data_word;
    res  = '0;
    done = 1'b0;
    if (req.first_word) begin
      restart_scan();
      word_idx    = '0;
      header_idx  = '0;
      header_seen = 1'b0;
    end
    idx = word_idx;
    // Index zero counts as a page start like any other multiple of the page size.
    if (idx[PAGE_BITS-1:0] == '0 && w == model_cfg.header_magic) begin
      header_idx  = idx;
      header_seen = 1'b1;
    end
    if ((w & model_cfg.prologue_mask) == model_cfg.prologue_pattern) begin
      prologue_idx     = idx;
      prologue_seen    = 1'b1;
      snap_header_idx  = header_idx;
      snap_header_seen = header_seen;
    end
    field   = w & model_cfg.register_field_mask;
    is_low  = (w & model_cfg.pair_mask) == model_cfg.low_half_pattern;
    is_high = (w & model_cfg.pair_mask) == model_cfg.high_half_pattern;
    // A word of the half already held, or of the other half with another field, is ignored.
    case (pair_phase)
      PH_HAVE_LOW:  done = is_high && field == held_field;
      PH_HAVE_HIGH: done = is_low && field == held_field;
      default: begin
        // A word that matches both halves starts a pair as the low half.
        if (is_low) begin
          pair_phase = PH_HAVE_LOW;
          held_field = field;
        end else if (is_high) begin
          pair_phase = PH_HAVE_HIGH;
          held_field = field;
        end else begin
          pair_phase = PH_WAIT;
        end
      end
    endcase
    word_idx = idx + 1'b1;
    if (done) begin
      img  = prologue_seen ? snap_header_seen : header_seen;
      base = prologue_seen ? snap_header_idx : header_idx;
      res.candidate_index  = prologue_seen ? prologue_idx : idx;
      res.prologue_found   = prologue_seen;
      res.pair_end_index   = idx;
      res.image_base_index = img ? base : '0;
      res.image_found      = img;
      // The header tracker survives a completed pair; only a new dump clears it.
      restart_scan();
    end
    return done;
  endfunction

  function automatic int idle_pct(idle_mode_e m, bit receiver);
    case (m)
      IDLE_SEND_HEAVY: return receiver ? 46 : 34;
      IDLE_RECV_HEAVY: return receiver ? 34 : 46;
      default:         return 0;
    endcase
  endfunction

  task automatic push_cfg(logic [CFG_INDEX_BITS-1:0] i, word_t v);
    scan_op_t op;
    op.is_cfg    = 1'b1;
    op.reg_index = i;
    op.value     = v;
    op.req       = '0;
    op.mode      = plan_mode;
    plan_cfg     = with_reg(plan_cfg, i, v);
    scan_ops_q.push_back(op);
  endtask

  task automatic push_setting(ipss_cfg_t s);
    push_cfg(REG_LOW_HALF_PATTERN,    s.low_half_pattern);
    push_cfg(REG_HIGH_HALF_PATTERN,   s.high_half_pattern);
    push_cfg(REG_PAIR_MASK,           s.pair_mask);
    push_cfg(REG_REGISTER_FIELD_MASK, s.register_field_mask);
    push_cfg(REG_PROLOGUE_MASK,       s.prologue_mask);
    push_cfg(REG_PROLOGUE_PATTERN,    s.prologue_pattern);
    push_cfg(REG_HEADER_MAGIC,        s.header_magic);
  endtask

  task automatic push_word(word_t w, bit first);
    scan_op_t op;
    op.is_cfg    = 1'b0;
    op.reg_index = '0;
    op.value     = '0;
    op.req       = '{data_word: w, first_word: first};
    op.mode      = plan_mode;
    plan_index   = first ? index_t'(1) : plan_index + 1'b1;
    scan_ops_q.push_back(op);
  endtask

  function automatic ipss_cfg_t random_setting();
    ipss_cfg_t s;
    s.pair_mask           = $urandom;
    s.low_half_pattern    = $urandom & s.pair_mask;
    s.high_half_pattern   = $urandom & s.pair_mask;
    s.register_field_mask = $urandom & ~s.pair_mask;
    // Now and then the field overlaps the compared bits, so the patterns decide it.
    if ($urandom_range(0, 3) == 0) s.register_field_mask |= $urandom;
    s.prologue_mask       = $urandom;
    s.prologue_pattern    = $urandom & s.prologue_mask;
    s.header_magic        = $urandom;
    return s;
  endfunction

  // Builds a word for index widx: mostly halves, prologues and headers under the
  // planned register file, with the shared field taken from field_val.
  function automatic word_t make_word(index_t widx, word_t field_val);
    word_t noise;
    word_t free_bits;
    int    pick;
    noise     = $urandom;
    pick      = $urandom_range(0, 99);
    free_bits = ~plan_cfg.pair_mask & ((field_val & plan_cfg.register_field_mask) |
                                       (noise & ~plan_cfg.register_field_mask));
    if (widx[PAGE_BITS-1:0] == '0 && pick < 60) return plan_cfg.header_magic;
    if (pick < 22) return (plan_cfg.low_half_pattern & plan_cfg.pair_mask) | free_bits;
    if (pick < 44) return (plan_cfg.high_half_pattern & plan_cfg.pair_mask) | free_bits;
    if (pick < 56) begin
      return (plan_cfg.prologue_pattern & plan_cfg.prologue_mask) |
             (noise & ~plan_cfg.prologue_mask);
    end
    return noise;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  // Driver: presents one request at a time from the plan, and performs register
  // writes only after the block has gone quiet with nothing owed.
  always @(posedge clk) begin : driver
    scan_op_t  head;
    ipss_out_t res;
    logic      valid_next;
    logic      we_next;
    valid_next = item_valid;
    we_next    = 1'b0;
    if (rst) begin
      valid_next = 1'b0;
    end else begin
      if (cfg_we) model_cfg = with_reg(model_cfg, cfg_index, cfg_data);
      if (item_valid && !item_stall) begin
        if (scan_word(item, res)) pair_results_q.push_back(res);
        valid_next   = 1'b0;
        quiet_cycles = 0;
      end
      if (!valid_next && scan_ops_q.size() != 0) begin
        head        = scan_ops_q[0];
        active_mode = head.mode;
        if (head.is_cfg) begin
          quiet_cycles = (pair_results_q.size() == 0) ? quiet_cycles + 1 : 0;
          if (quiet_cycles > SETTLE_CYCLES) begin
            we_next   = 1'b1;
            cfg_index <= head.reg_index;
            cfg_data  <= head.value;
            void'(scan_ops_q.pop_front());
          end
        end else if ($urandom_range(0, 99) >= idle_pct(head.mode, 1'b0)) begin
          valid_next = 1'b1;
          item       <= head.req;
          void'(scan_ops_q.pop_front());
        end
      end
    end
    item_valid <= valid_next;
    cfg_we     <= we_next;
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // stalls the result channel at random.
  always @(posedge clk) begin : monitor
    ipss_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pair_results_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result with nothing expected, expected none, actual %p",
                     $time, result);
          end
        end else begin
          want = pair_results_q.pop_front();
          check_field("candidate_index",  want.candidate_index,  result.candidate_index);
          check_field("prologue_found",   want.prologue_found,   result.prologue_found);
          check_field("pair_end_index",   want.pair_end_index,   result.pair_end_index);
          check_field("image_base_index", want.image_base_index, result.image_base_index);
          check_field("image_found",      want.image_found,      result.image_found);
        end
      end
      result_stall <= ($urandom_range(0, 99) < idle_pct(active_mode, 1'b1));
    end
  end

  // Watchdog: ends the run when nothing has moved on any port for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
        stuck = 0;
      else
        stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int    k;
    bit    first;
    word_t seg_field;

    // Directed words under the reset register values.
    plan_mode = IDLE_SEND_HEAVY;
    push_word(RST_HEADER_MAGIC, 1'b1);   // header on index zero
    push_word(32'hE92D_4010, 1'b0);      // prologue
    push_word(32'hE30D_3600, 1'b0);      // low half, r3
    push_word(32'hE30D_5600, 1'b0);      // same half again: ignored, r3 kept
    push_word(32'hE340_5083, 1'b0);      // high half with another register: ignored
    push_word(32'hE340_3083, 1'b0);      // high half r3 completes the pair
    push_word(32'hE340_7083, 1'b0);      // high half first, r7
    push_word(32'hE340_1083, 1'b0);      // same half again
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hE30D_7600, 1'b0);      // completes without a prologue
    push_word(32'hE30D_2600, 1'b0);      // pair started, then cut by a new dump
    push_word(32'hE92D_FFFF, 1'b1);      // new dump without a header, prologue at zero
    push_word(32'hE340_2083, 1'b0);
    push_word(32'hE30D_2600, 1'b0);      // completes, no image found
    // All-zero registers: each word is both halves and a prologue, so the
    // completing word is itself the prologue.
    push_setting(ZERO_SETTING);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_0000, 1'b1);      // header magic of zero at index zero
    push_word(32'h1234_5678, 1'b0);

    // Random part: dumps of random length with one long dump across a page start.
    seg_field = $urandom;
    for (k = 0; k < RANDOM_WORDS; k++) begin
      plan_mode = (k < MODE_SPAN) ? IDLE_SEND_HEAVY :
                  (k < 2 * MODE_SPAN) ? IDLE_RECV_HEAVY : IDLE_NONE;
      if (k % SETTING_SPAN == 0) begin
        case (k / SETTING_SPAN)
          0:       push_setting(RESET_SETTING);
          2:       push_setting(ONES_SETTING);
          4:       push_setting(ZERO_SETTING);
          default: push_setting(random_setting());
        endcase
      end
      first = (k == LONG_START) ||
              ((k < LONG_START || k >= LONG_START + LONG_WORDS) &&
               $urandom_range(0, 29) == 0);
      if (first) seg_field = $urandom;
      push_word(make_word(first ? index_t'(0) : plan_index,
                          ($urandom_range(0, 3) == 0) ? word_t'($urandom) : seg_field),
                first);
    end

    do @(negedge clk);
    while (scan_ops_q.size() != 0 || item_valid || pair_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pair_results_q.size() != 0) begin
      $display("%0t: results never delivered, expected %0d more, actual 0",
               $time, pair_results_q.size());
      errors += pair_results_q.size();
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
